// ===== rtl/core/ffra_pkg.sv =====
// First-fit region allocator: shared types and constants.
// Used by the channel interfaces, the allocator top level and the testbench; depends on nothing.
package ffra_pkg;

  localparam int unsigned DATA_W   = 24;
  localparam int unsigned LIMIT_W  = 25;
  localparam int unsigned STATUS_W = 3;

  // first usable offset and size of the addressable space
  localparam logic [LIMIT_W-1:0] BASE_OFFSET = 25'd4;
  localparam logic [LIMIT_W-1:0] ADDR_SPAN   = 25'h100_0000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_SIZE  = 3'd1,
    STATUS_NO_SPACE  = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SHIFT_UP,
    ST_INSERT,
    ST_SHIFT_DN,
    ST_RESP
  } state_e;

  // one row of the region table
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
  } entry_t;

endpackage

// ===== rtl/core/ffra_req_if.sv =====
// Request channel of the region allocator: valid/ready plus request word.
// Depends on ffra_pkg.
interface ffra_req_if import ffra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [DATA_W-1:0] size;
  logic [DATA_W-1:0] position;

  modport source (output valid, output req_type, output size, output position, input ready);
  modport sink   (input valid, input req_type, input size, input position, output ready);
endinterface

// ===== rtl/core/ffra_rsp_if.sv =====
// Response channel of the region allocator: valid/ready plus result word.
// Depends on ffra_pkg.
interface ffra_rsp_if import ffra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   region_offset;

  modport source (output valid, output status, output region_offset, input ready);
  modport sink   (input valid, input status, input region_offset, output ready);
endinterface

// ===== rtl/core/first_fit_region_allocator.sv =====
// First-fit region allocator: keeps up to MAX_REGIONS regions (start, length) sorted by start in
// one synchronous memory. An allocate request walks the table from offset 4 and takes the first
// gap that fits, else the space after the last region, then opens a slot by moving later rows
// up; a free request looks for the matching start and closes the hole by moving later rows down.
// One request is handled at a time. An allocate of zero size or on a full table, or a free on an
// empty table, goes straight to the result word; an allocate on an empty table only checks the
// limit first; an allocate that opens a slot or a free that closes a hole also moves rows: the
// scan and the move between them touch each row about once, one row per cycle, limited by the
// single read and single write port of the region memory. The result word waits until the output
// register is free, and the next request is taken once the result sits in the output register.
// space_limit is written over the APB port at address 0.
// Depends on ffra_pkg, ffra_req_if and ffra_rsp_if.
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffra_req_if.sink    req_i,
  ffra_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  // region memory
  entry_t          region_mem_q [MAX_REGIONS];
  entry_t          rdata_q;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  // control state
  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        slot_q, slot_d;
  logic [LIMIT_W-1:0]   xpos_q, xpos_d;
  logic [LIMIT_W-1:0]   space_limit_q;
  logic                 rsp_valid_q, rsp_valid_d;

  // request and result words
  req_type_e            req_type_q, req_type_d;
  logic [DATA_W-1:0]    size_q, size_d;
  logic [DATA_W-1:0]    pos_q, pos_d;
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    offset_q, offset_d;
  logic [STATUS_W-1:0]  rsp_status_q, rsp_status_d;
  logic [DATA_W-1:0]    rsp_offset_q, rsp_offset_d;

  // datapath terms
  logic [LIMIT_W-1:0]   limit;
  logic [LIMIT_W:0]     end_sum;
  logic                 last_row;
  logic [CW-1:0]        idx_nxt;
  logic [CW-1:0]        idx_up2;
  logic [CW-1:0]        idx_dn2;
  logic [CW-1:0]        cnt_last;
  logic                 cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {{(32 - LIMIT_W){1'b0}}, space_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_limit_q <= ADDR_SPAN;
    end else if (cfg_wr) begin
      space_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // clamp the limit so every start fits in 24 bits
  assign limit    = (space_limit_q > ADDR_SPAN) ? ADDR_SPAN : space_limit_q;
  assign end_sum  = {1'b0, xpos_q} + {2'b0, size_q};
  assign last_row = (idx_q == count_q - ONE);
  assign idx_nxt  = idx_q + ONE;
  assign idx_up2  = idx_q + TWO;
  assign idx_dn2  = idx_q - TWO;
  assign cnt_last = count_q - ONE;

  // channel outputs
  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.region_offset = rsp_offset_q;

  // region memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      region_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= region_mem_q[mem_raddr];
    end
  end

  // next state, memory control and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    xpos_d       = xpos_q;
    req_type_d   = req_type_q;
    size_d       = size_q;
    pos_d        = pos_q;
    status_d     = status_q;
    offset_d     = offset_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_offset_d = rsp_offset_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_type_d = req_type_e'(req_i.req_type);
          size_d     = req_i.size;
          pos_d      = req_i.position;
          offset_d   = '0;
          xpos_d     = BASE_OFFSET;
          idx_d      = '0;
          if (req_i.req_type == REQ_ALLOC) begin
            priority if (req_i.size == '0) begin
              status_d = STATUS_BAD_SIZE;
              state_d  = ST_RESP;
            end else if (count_q == MAX_CNT) begin
              status_d = STATUS_FULL;
              state_d  = ST_RESP;
            end else if (count_q == '0) begin
              slot_d  = '0;
              state_d = ST_CHECK;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = ST_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_NOT_FOUND;
              state_d  = ST_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // fetch the following row while the current one is examined
        if (idx_nxt < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_nxt[AW-1:0];
        end
        if (req_type_q == REQ_ALLOC) begin
          if ({2'b0, rdata_q.start} >= end_sum) begin
            slot_d  = idx_q;
            state_d = ST_CHECK;
          end else begin
            xpos_d = {1'b0, rdata_q.start} + {1'b0, rdata_q.length};
            if (last_row) begin
              slot_d  = count_q;
              state_d = ST_CHECK;
            end else begin
              idx_d = idx_nxt;
            end
          end
        end else begin
          priority if (rdata_q.start == pos_q) begin
            if (last_row) begin
              count_d  = count_q - ONE;
              status_d = STATUS_OK;
              state_d  = ST_RESP;
            end else begin
              state_d = ST_SHIFT_DN;
            end
          end else if (last_row) begin
            status_d = STATUS_NOT_FOUND;
            state_d  = ST_RESP;
          end else begin
            idx_d = idx_nxt;
          end
        end
      end

      ST_SHIFT_DN: begin
        // move row idx+1 (now in rdata) down to idx
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
        if (idx_nxt == count_q - ONE) begin
          count_d  = count_q - ONE;
          status_d = STATUS_OK;
          state_d  = ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_up2[AW-1:0];
          idx_d     = idx_nxt;
        end
      end

      ST_CHECK: begin
        if (end_sum > {1'b0, limit}) begin
          status_d = STATUS_NO_SPACE;
          state_d  = ST_RESP;
        end else if (slot_q == count_q) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
          mem_wdata = '{start: xpos_q[DATA_W-1:0], length: size_q};
          count_d   = count_q + ONE;
          status_d  = STATUS_OK;
          offset_d  = xpos_q[DATA_W-1:0];
          state_d   = ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_last[AW-1:0];
          idx_d     = count_q;
          state_d   = ST_SHIFT_UP;
        end
      end

      ST_SHIFT_UP: begin
        // move row idx-1 (now in rdata) up to idx
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
        if (idx_q - ONE == slot_q) begin
          state_d = ST_INSERT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dn2[AW-1:0];
          idx_d     = idx_q - ONE;
        end
      end

      ST_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q[AW-1:0];
        mem_wdata = '{start: xpos_q[DATA_W-1:0], length: size_q};
        count_d   = count_q + ONE;
        status_d  = STATUS_OK;
        offset_d  = xpos_q[DATA_W-1:0];
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        // hand the word to the output register once it is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_offset_d = offset_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    xpos_q       <= xpos_d;
    req_type_q   <= req_type_d;
    size_q       <= size_d;
    pos_q        <= pos_d;
    status_q     <= status_d;
    offset_q     <= offset_d;
    rsp_status_q <= rsp_status_d;
    rsp_offset_q <= rsp_offset_d;
  end

endmodule

// ===== sim/tb_first_fit_region_allocator.sv =====
// Testbench for first_fit_region_allocator: directed and random allocate/free traffic,
// checked word by word against a region table kept alongside the block.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if and the allocator top level.
module tb_first_fit_region_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffra_pkg::*;

  localparam int unsigned MAX_REGIONS = 32;
  localparam int unsigned REG_SPACE_LIMIT = 0;
  localparam logic [1:0] SPACE_LIMIT_ADDR = 2'(4 * REG_SPACE_LIMIT);
  localparam int unsigned LIMIT_LOW = 5;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_REGIONS + 8;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  // one expected reply word
  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] offset;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffra_req_if req_if ();
  ffra_rsp_if rsp_if ();

  first_fit_region_allocator #(
    .MAX_REGIONS(MAX_REGIONS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the region table and the limit register
  logic [DATA_W-1:0]  tbl_start [MAX_REGIONS];
  logic [DATA_W-1:0]  tbl_len   [MAX_REGIONS];
  int unsigned        tbl_count;
  logic [LIMIT_W-1:0] limit_q;

  grant_t grant_q[$];

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_limits;
  int unsigned status_seen [8];

  // sender and receiver idling controls
  bit          sender_gaps;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned hold_reqs;
  int unsigned hold_len;
  bit          filling;

  // first fit from offset 4, insert in order; updates the shadow table
  function automatic grant_t place_region(logic [DATA_W-1:0] size);
    grant_t      g;
    int unsigned cand;
    int unsigned lim;
    int unsigned slot;
    bit          found;
    g.status = STATUS_OK;
    g.offset = '0;
    cand = BASE_OFFSET;
    slot = tbl_count;
    found = 1'b0;
    if (size == '0) begin
      g.status = STATUS_BAD_SIZE;
    end else if (tbl_count >= MAX_REGIONS) begin
      g.status = STATUS_FULL;
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!found) begin
          if (tbl_start[i] >= cand + size) begin
            slot = i;
            found = 1'b1;
          end else begin
            cand = tbl_start[i] + tbl_len[i];
          end
        end
      end
      lim = (limit_q > ADDR_SPAN) ? ADDR_SPAN : limit_q;
      if (cand + size > lim) begin
        g.status = STATUS_NO_SPACE;
      end else begin
        for (int i = tbl_count; i > slot; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_len[i]   = tbl_len[i-1];
        end
        tbl_start[slot] = cand[DATA_W-1:0];
        tbl_len[slot]   = size;
        tbl_count++;
        g.offset = cand[DATA_W-1:0];
      end
    end
    return g;
  endfunction

  // drop the entry whose start matches, closing the hole
  function automatic grant_t remove_region(logic [DATA_W-1:0] pos);
    grant_t g;
    bit     hit;
    g.status = STATUS_NOT_FOUND;
    g.offset = '0;
    hit = 1'b0;
    for (int i = 0; i < tbl_count; i++) begin
      if (!hit && tbl_start[i] == pos) begin
        hit = 1'b1;
        for (int j = i; j + 1 < tbl_count; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_len[j]   = tbl_len[j+1];
        end
      end
    end
    if (hit) begin
      tbl_count--;
      g.status = STATUS_OK;
    end
    return g;
  endfunction

  // offer one request word, honour burst gaps, and record its expected reply
  task automatic send_request(req_type_e kind, logic [DATA_W-1:0] size,
                              logic [DATA_W-1:0] pos);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.size     <= size;
    req_if.position <= pos;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (burst_left > 0) burst_left--;
    n_sent++;
    if (kind == REQ_ALLOC) grant_q.push_back(place_region(size));
    else grant_q.push_back(remove_region(pos));
  endtask

  // hold the sender until every reply is back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write space_limit over APB once the block is idle
  task automatic write_space_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPACE_LIMIT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_q = value;
    n_limits++;
  endtask

  // free every stored region, lowest start first
  task automatic clear_table();
    while (tbl_count > 0) send_request(REQ_FREE, 24'($urandom), tbl_start[0]);
  endtask

  // one random request, steered by how full the table is
  task automatic random_request(int unsigned size_cap);
    int unsigned       r;
    logic [DATA_W-1:0] sz;
    logic [DATA_W-1:0] pos;
    if (tbl_count >= MAX_REGIONS) filling = 1'b0;
    else if (tbl_count == 0) filling = 1'b1;
    else if ($urandom_range(0, 99) < 2) filling = ~filling;
    r = $urandom_range(0, 99);
    if (r < (filling ? 70 : 25)) begin
      r = $urandom_range(0, 99);
      if (r < 5) sz = '0;
      else if (r < 10) sz = 24'($urandom);
      else sz = 24'($urandom_range(1, size_cap));
      send_request(REQ_ALLOC, sz, 24'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (tbl_count > 0 && r < 85) pos = tbl_start[$urandom_range(0, tbl_count - 1)];
      else if (tbl_count > 0 && r < 92) pos = tbl_start[$urandom_range(0, tbl_count - 1)] + 1'b1;
      else pos = 24'($urandom);
      send_request(REQ_FREE, 24'($urandom), pos);
    end
  endtask

  // gaps, exact fits, the space edge and unmatched frees
  task automatic test_edge_requests();
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    send_request(REQ_ALLOC, 24'h0, 24'hFF_FFFF);
    send_request(REQ_FREE, 24'hFF_FFFF, 24'h0);
    send_request(REQ_ALLOC, 24'hFF_FFFF, 24'h0);
    send_request(REQ_ALLOC, 24'hFF_FFFC, 24'hFF_FFFF);
    send_request(REQ_ALLOC, 24'd1, 24'h0);
    send_request(REQ_FREE, 24'h0, 24'd4);
    send_request(REQ_ALLOC, 24'd16, 24'h0);
    send_request(REQ_ALLOC, 24'd16, 24'h0);
    send_request(REQ_ALLOC, 24'd16, 24'h0);
    send_request(REQ_FREE, 24'h0, 24'd20);
    send_request(REQ_ALLOC, 24'd8, 24'h0);
    send_request(REQ_ALLOC, 24'd16, 24'h0);
    send_request(REQ_ALLOC, 24'd8, 24'h0);
    send_request(REQ_FREE, 24'h0, 24'hFF_FFFF);
    send_request(REQ_FREE, 24'h0, 24'd4);
    send_request(REQ_ALLOC, 24'd17, 24'h0);
    send_request(REQ_ALLOC, 24'd16, 24'h0);
    send_request(REQ_FREE, 24'h0, 24'd21);
    clear_table();
    wait_idle();
  endtask

  // fill every slot, then hit the full table with good and zero sizes
  task automatic test_table_full();
    sender_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    clear_table();
    for (int i = 0; i < MAX_REGIONS; i++) send_request(REQ_ALLOC, 24'($urandom_range(1, 3)), '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_ALLOC, 24'h0, '0);
    send_request(REQ_FREE, '0, tbl_start[MAX_REGIONS/2]);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    wait_idle();
  endtask

  // the smallest limit leaves room for one region of size 1 only
  task automatic test_tight_limit();
    clear_table();
    write_space_limit(LIMIT_W'(LIMIT_LOW));
    send_request(REQ_ALLOC, 24'd2, '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_FREE, '0, 24'd4);
    for (int i = 0; i < 80; i++) random_request(3);
    write_space_limit(ADDR_SPAN);
  endtask

  // stall the receiver for a long stretch while requests keep coming,
  // then pause the sender until all replies are home, and send more
  task automatic test_backpressure();
    write_space_limit(LIMIT_W'(300));
    sender_gaps = 1'b0;
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 60; i++) random_request(20);
    hold_len = 600;
    hold_reqs++;
    for (int i = 0; i < 120; i++) random_request(20);
    wait_idle();
    for (int i = 0; i < 120; i++) random_request(20);
  endtask

  // random traffic across several limits and idling styles
  task automatic test_random_traffic();
    int unsigned lim;
    write_space_limit(ADDR_SPAN);
    sender_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 300; i++) random_request(400000);
    write_space_limit(LIMIT_W'(4096));
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    for (int i = 0; i < 250; i++) random_request(200);
    lim = $urandom_range(LIMIT_LOW, ADDR_SPAN);
    write_space_limit(LIMIT_W'(lim));
    sender_gaps = 1'b1;
    rx_mode = RX_PATTERN;
    for (int i = 0; i < 250; i++) random_request(lim / 30 + 1);
    write_space_limit(ADDR_SPAN);
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 200; i++) random_request(16);
  endtask

  // receive and check reply words; drive ready on its own pattern
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned rx_cycle;
    grant_t      exp_g;
    hold_served = 0;
    hold_left = 0;
    rx_cycle = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (grant_q.size() == 0) begin
          $error("reply with no request waiting: status %0d, region_offset %0d",
                 rsp_if.status, rsp_if.region_offset);
          n_errors++;
        end else begin
          exp_g = grant_q.pop_front();
          n_checked++;
          status_seen[exp_g.status]++;
          if (rsp_if.status !== exp_g.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_g.status, rsp_if.status);
            n_errors++;
          end
          if (rsp_if.region_offset !== exp_g.offset) begin
            $error("region_offset mismatch: expected %0d, got %0d",
                   exp_g.offset, rsp_if.region_offset);
            n_errors++;
          end
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: rsp_if.ready <= 1'b1;
          RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 2) != 0);
          default:   rsp_if.ready <= (rx_cycle % 5 != 0) && (rx_cycle % 13 > 2);
        endcase
      end
    end
  end

  // give up if the run hangs
  initial begin
    #20_000_000;
    $display("[first_fit_region_allocator] ERROR");
    $finish;
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_limits = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    tbl_count = 0;
    limit_q = ADDR_SPAN;
    sender_gaps = 1'b0;
    burst_left = 0;
    rx_mode = RX_ALWAYS;
    hold_reqs = 0;
    hold_len = 0;
    filling = 1'b1;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_ALLOC;
    req_if.size     <= '0;
    req_if.position <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_edge_requests();
    test_table_full();
    test_tight_limit();
    test_backpressure();
    test_random_traffic();

    // let the last replies land, then allow for any late stray word
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d replies checked, %0d limit writes", n_sent, n_checked,
             n_limits);
    $display("replies: ok %0d, bad size %0d, no space %0d, table full %0d, not found %0d",
             status_seen[STATUS_OK], status_seen[STATUS_BAD_SIZE],
             status_seen[STATUS_NO_SPACE], status_seen[STATUS_FULL],
             status_seen[STATUS_NOT_FOUND]);
    if (n_errors == 0 && grant_q.size() == 0) begin
      $display("[first_fit_region_allocator] OK");
    end else begin
      $display("[first_fit_region_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ffra_pkg.sv
rtl/core/ffra_req_if.sv
rtl/core/ffra_rsp_if.sv
rtl/core/first_fit_region_allocator.sv
sim/tb_first_fit_region_allocator.sv
